// ===== rtl/mctt_pkg.sv =====
package mctt_pkg;

    localparam int ACTION_W  = 2;
    localparam int CHANNEL_W = 4;
    localparam int PERIOD_W  = 16;
    localparam int PINS_W    = 16;
    localparam int COUNT_W   = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK     = 2'd0,
        ACT_PLAY     = 2'd1,
        ACT_STOP     = 2'd2,
        ACT_STOP_ALL = 2'd3
    } t_action;

    typedef struct packed {
        logic                 valid;
        t_action              action;
        logic [CHANNEL_W-1:0] channel;
        logic [PERIOD_W-1:0]  period;
        logic                 tick_en;
        logic                 was_active;
    } t_token;

endpackage

// ===== rtl/multichannel_tone_toggle_generator.sv =====
// Channel | Signals                          | Item contents (lowest bit first)
// input   | i_s_tvalid o_s_tready i_s_tdata  | action[1:0] channel[5:2] period[21:6]
// output  | o_m_tvalid i_m_tready o_m_tdata  | pin_levels[15:0] active_count[20:16]
//
// An item passes along the row of channel cells, one cell per cycle, and its
// result is registered for output as it leaves the last cell.
// A new item is accepted in the cycle after the previous one has left the last
// cell, so only one item is in the row at a time.
// Reset clears every channel and the note count at once.
// If the output is stalled the item waits in the last cell; input stays closed.
module multichannel_tone_toggle_generator #(
    parameter int CHANNELS    = 16,
    parameter int PERIOD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // action, channel, period, zero padding
    input  logic [mctt_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // pin_levels, active_count, zero padding
    output logic [mctt_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    localparam int LAST = CHANNELS - 1;

    mctt_pkg::t_token r_tok   [CHANNELS];
    mctt_pkg::t_token w_tok_nx[CHANNELS];
    logic [CHANNELS-1:0] w_fire;
    logic [CHANNELS-1:0] w_valid;
    logic [CHANNELS-1:0] w_pin;
    logic [CHANNELS-1:0] w_pin_nx;
    logic [CHANNELS-1:0] w_pins_out;

    logic                          r_busy;
    logic [mctt_pkg::COUNT_W-1:0]  r_count;
    logic [mctt_pkg::COUNT_W-1:0]  n_count;
    logic                          r_out_valid;
    logic [mctt_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                          accept;
    mctt_pkg::t_token              in_tok;
    mctt_pkg::t_token              last_tok;

    assign o_s_tready = ~r_busy;
    assign accept     = i_s_tvalid & o_s_tready;

    always_comb begin
        in_tok            = '0;
        in_tok.valid      = 1'b1;
        in_tok.action     = mctt_pkg::t_action'(i_s_tdata[1:0]);
        in_tok.channel    = i_s_tdata[5:2];
        in_tok.period     = i_s_tdata[21:6];
        in_tok.tick_en    = (r_count != '0);
        in_tok.was_active = 1'b0;
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        assign w_valid[g] = r_tok[g].valid;
        if (g == LAST) begin : g_last
            assign w_fire[g] = r_tok[g].valid & (~r_out_valid | i_m_tready);
            assign w_pins_out[g] = w_pin_nx[g];
        end else begin : g_mid
            assign w_fire[g] = r_tok[g].valid;
            assign w_pins_out[g] = w_pin[g];
        end

        mctt_cell #(
            .CELL_IDX    (g),
            .PERIOD_BITS (PERIOD_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_fire   (w_fire[g]),
            .i_tok    (r_tok[g]),
            .o_tok    (w_tok_nx[g]),
            .o_pin    (w_pin[g]),
            .o_pin_nx (w_pin_nx[g])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tok[g] <= '0;
            end else begin
                if (g == 0) begin
                    if (accept) begin
                        r_tok[g] <= in_tok;
                    end else if (w_fire[g]) begin
                        r_tok[g].valid <= 1'b0;
                    end
                end else begin
                    if (w_fire[(g == 0) ? 0 : g - 1]) begin
                        r_tok[g] <= w_tok_nx[(g == 0) ? 0 : g - 1];
                    end else if (w_fire[g]) begin
                        r_tok[g].valid <= 1'b0;
                    end
                end
            end
        end
    end

    assign last_tok = w_tok_nx[LAST];

    always_comb begin
        n_count = r_count;
        unique case (last_tok.action)
            mctt_pkg::ACT_TICK: begin
            end
            mctt_pkg::ACT_PLAY: begin
                if (!last_tok.was_active &&
                    (r_count < mctt_pkg::COUNT_W'(CHANNELS))) begin
                    n_count = r_count + mctt_pkg::COUNT_W'(1);
                end
            end
            mctt_pkg::ACT_STOP: begin
                if (last_tok.was_active && (r_count != '0)) begin
                    n_count = r_count - mctt_pkg::COUNT_W'(1);
                end
            end
            mctt_pkg::ACT_STOP_ALL: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (w_fire[LAST]) begin
                r_busy <= 1'b0;
            end
            if (w_fire[LAST]) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire[LAST]) begin
            r_out_data <= mctt_pkg::OUT_DATA_W'({n_count,
                                                mctt_pkg::PINS_W'(w_pins_out)});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) <= 1)
        else $error("More than one item in the cell row.");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_valid == '0))
        else $error("Cell row holds an item while input is open.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mctt_pkg::COUNT_W'(CHANNELS))
        else $error("Note count exceeds the number of channels.");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_fire[LAST]))
        else $error("Result offered without an item leaving the last cell.");
`endif

endmodule

// ===== rtl/mctt_cell.sv =====
module mctt_cell #(
    parameter int CELL_IDX    = 0,
    parameter int PERIOD_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  mctt_pkg::t_token i_tok,
    output mctt_pkg::t_token o_tok,
    output logic            o_pin,
    output logic            o_pin_nx
);

    logic                   r_active;
    logic [PERIOD_BITS-1:0] r_half;
    logic [PERIOD_BITS-1:0] r_cnt;
    logic                   r_tog;
    logic                   r_pin;

    logic                   n_active;
    logic [PERIOD_BITS-1:0] n_half;
    logic [PERIOD_BITS-1:0] n_cnt;
    logic                   n_tog;
    logic                   n_pin;
    logic                   hit;

    assign hit = (i_tok.channel == mctt_pkg::CHANNEL_W'(CELL_IDX));

    always_comb begin
        n_active = r_active;
        n_half   = r_half;
        n_cnt    = r_cnt;
        n_tog    = r_tog;
        n_pin    = r_pin;
        o_tok    = i_tok;
        o_tok.was_active = i_tok.was_active | (hit & r_active);
        unique case (i_tok.action)
            mctt_pkg::ACT_TICK: begin
                if (i_tok.tick_en && (r_half != '0)) begin
                    if (r_cnt >= r_half) begin
                        n_tog = ~r_tog;
                        n_pin = ~r_tog;
                        n_cnt = '0;
                    end else begin
                        n_cnt = r_cnt + PERIOD_BITS'(1);
                    end
                end
            end
            mctt_pkg::ACT_PLAY: begin
                if (hit) begin
                    n_active = 1'b1;
                    n_half   = PERIOD_BITS'(i_tok.period);
                end
            end
            mctt_pkg::ACT_STOP: begin
                if (hit) begin
                    n_active = 1'b0;
                    n_half   = '0;
                    n_pin    = 1'b0;
                end
            end
            mctt_pkg::ACT_STOP_ALL: begin
                n_active = 1'b0;
                n_half   = '0;
                n_cnt    = '0;
                n_tog    = 1'b0;
                n_pin    = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_half   <= '0;
            r_cnt    <= '0;
            r_tog    <= 1'b0;
            r_pin    <= 1'b0;
        end else if (i_fire) begin
            r_active <= n_active;
            r_half   <= n_half;
            r_cnt    <= n_cnt;
            r_tog    <= n_tog;
            r_pin    <= n_pin;
        end
    end

    assign o_pin    = r_pin;
    assign o_pin_nx = n_pin;

endmodule

// ===== dv/tb_multichannel_tone_toggle_generator.sv =====
module tb_multichannel_tone_toggle_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH        = 16;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int PHASE_ITEMS   = 285;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LONG_HOLD     = 400;

    typedef struct packed {
        logic [mctt_pkg::COUNT_W-1:0] active_count;
        logic [mctt_pkg::PINS_W-1:0]  pin_levels;
    } t_tone_result;

    class tone_bank_scoreboard;
        bit                          active[NUM_CH];
        bit [mctt_pkg::PERIOD_W-1:0] half_per[NUM_CH];
        bit [mctt_pkg::PERIOD_W-1:0] counter[NUM_CH];
        bit                          phase[NUM_CH];
        bit                          pin[NUM_CH];
        bit [mctt_pkg::COUNT_W-1:0]  notes;
        t_tone_result                expected_levels[$];
        int                          errors;

        function void clear_bank();
            for (int c = 0; c < NUM_CH; c++) begin
                active[c]   = 1'b0;
                half_per[c] = '0;
                counter[c]  = '0;
                phase[c]    = 1'b0;
                pin[c]      = 1'b0;
            end
            notes = '0;
        endfunction

        function new();
            errors = 0;
            clear_bank();
        endfunction

        function void note_item(mctt_pkg::t_action act,
                                logic [mctt_pkg::CHANNEL_W-1:0] ch,
                                logic [mctt_pkg::PERIOD_W-1:0] per);
            t_tone_result res;
            case (act)
                mctt_pkg::ACT_TICK: begin
                    if (notes != 0) begin
                        for (int c = 0; c < NUM_CH; c++) begin
                            if (half_per[c] != 0) begin
                                if (counter[c] >= half_per[c]) begin
                                    phase[c]   = ~phase[c];
                                    pin[c]     = phase[c];
                                    counter[c] = '0;
                                end else begin
                                    counter[c] = counter[c] + 1'b1;
                                end
                            end
                        end
                    end
                end
                mctt_pkg::ACT_PLAY: begin
                    if (!active[ch] && notes < NUM_CH)
                        notes = notes + 1'b1;
                    active[ch]   = 1'b1;
                    half_per[ch] = per;
                end
                mctt_pkg::ACT_STOP: begin
                    if (active[ch] && notes > 0)
                        notes = notes - 1'b1;
                    active[ch]   = 1'b0;
                    half_per[ch] = '0;
                    pin[ch]      = 1'b0;
                end
                default: begin
                    clear_bank();
                end
            endcase
            for (int c = 0; c < NUM_CH; c++)
                res.pin_levels[c] = pin[c];
            res.active_count = notes;
            expected_levels.push_back(res);
        endfunction

        function void check_result(logic [mctt_pkg::OUT_DATA_W-1:0] data);
            t_tone_result exp_res;
            if (expected_levels.size() == 0) begin
                $error("unexpected result item: %h", data);
                errors++;
                return;
            end
            exp_res = expected_levels.pop_front();
            if (data[mctt_pkg::PINS_W-1:0] !== exp_res.pin_levels) begin
                $error("pin_levels mismatch: expected %h, actual %h",
                       exp_res.pin_levels, data[mctt_pkg::PINS_W-1:0]);
                errors++;
            end
            if (data[mctt_pkg::PINS_W+mctt_pkg::COUNT_W-1:mctt_pkg::PINS_W] !==
                exp_res.active_count) begin
                $error("active_count mismatch: expected %0d, actual %0d",
                       exp_res.active_count,
                       data[mctt_pkg::PINS_W+mctt_pkg::COUNT_W-1:mctt_pkg::PINS_W]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            s_tvalid   = 1'b0;
    logic [mctt_pkg::IN_DATA_W-1:0]  s_tdata    = '0;
    logic                            m_tready   = 1'b0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic [mctt_pkg::OUT_DATA_W-1:0] m_tdata;

    int                    idle_pct   = 0;
    int                    stall_pct  = 0;
    int                    hold_left  = 0;
    int                    cycles     = 0;
    tone_bank_scoreboard   sb;

    multichannel_tone_toggle_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The long hold-off is counted down here, one cycle at a time.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(input mctt_pkg::t_action act,
                             input logic [mctt_pkg::CHANNEL_W-1:0] ch,
                             input logic [mctt_pkg::PERIOD_W-1:0] per);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, per, ch, act};
        do
            @(posedge i_clk);
        while (!s_tready);
        sb.note_item(act, ch, per);
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_random_item();
        mctt_pkg::t_action             act;
        logic [mctt_pkg::PERIOD_W-1:0] per;
        int                            pick;
        pick = $urandom_range(99);
        if (pick < 50)
            act = mctt_pkg::ACT_TICK;
        else if (pick < 80)
            act = mctt_pkg::ACT_PLAY;
        else if (pick < 97)
            act = mctt_pkg::ACT_STOP;
        else
            act = mctt_pkg::ACT_STOP_ALL;
        pick = $urandom_range(99);
        if (pick < 70)
            per = mctt_pkg::PERIOD_W'($urandom_range(6));
        else if (pick < 94)
            per = mctt_pkg::PERIOD_W'($urandom_range(40, 7));
        else
            per = mctt_pkg::PERIOD_W'($urandom);
        send_item(act, mctt_pkg::CHANNEL_W'($urandom_range(NUM_CH - 1)), per);
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A tick with no note held must leave everything unchanged.
        send_item(mctt_pkg::ACT_TICK, 4'd0, 16'd0);
        send_item(mctt_pkg::ACT_PLAY, 4'd0, 16'd0);
        send_item(mctt_pkg::ACT_PLAY, 4'd1, 16'd1);
        send_item(mctt_pkg::ACT_PLAY, 4'd15, 16'hFFFF);
        send_item(mctt_pkg::ACT_PLAY, 4'd1, 16'd2);
        repeat (4) send_item(mctt_pkg::ACT_TICK, 4'd0, 16'd0);
        send_item(mctt_pkg::ACT_PLAY, 4'd9, 16'd0);
        send_item(mctt_pkg::ACT_TICK, 4'd0, 16'd0);
        send_item(mctt_pkg::ACT_STOP, 4'd1, 16'd0);
        send_item(mctt_pkg::ACT_STOP, 4'd7, 16'hFFFF);
        send_item(mctt_pkg::ACT_TICK, 4'd0, 16'd0);
        send_item(mctt_pkg::ACT_STOP_ALL, 4'd0, 16'd0);
        send_item(mctt_pkg::ACT_TICK, 4'd0, 16'd0);
        send_item(mctt_pkg::ACT_STOP, 4'd3, 16'd0);
        send_item(mctt_pkg::ACT_PLAY, 4'd4, 16'd1);
        repeat (3) send_item(mctt_pkg::ACT_TICK, 4'd0, 16'd0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; hold_left = LONG_HOLD; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
        end

        idle_pct  = 0;
        stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
